@@ design/length_prefixed_message_fifo_macros.svh @@
// Assertion macros for the message FIFO design file.
// Both expect a signal named clock in the scope of use; LPMF_ASSERT also expects reset.
`ifndef LENGTH_PREFIXED_MESSAGE_FIFO_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_FIFO_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LPMF_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define LPMF_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ design/lpmf_pkg.sv @@
`timescale 1ns / 1ps

package lpmf_pkg;

   // Field widths of the request and response beats
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 12;
   localparam int STATUS_W = 2;

   // Function codes of a request beat
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   // Status codes of a response beat
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd3;

   // Largest length that a header of one byte or of two or more bytes records
   localparam logic [LEN_W-1:0] LEN_LIMIT_SHORT = 12'h0FF;
   localparam logic [LEN_W-1:0] LEN_LIMIT_FULL  = 12'hFFF;

endpackage

@@ design/lpmf_ram.sv @@
`timescale 1ns / 1ps

module lpmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/length_prefixed_message_fifo.sv @@
`timescale 1ns / 1ps

// Byte ring buffer that stores whole messages, each behind a little-endian
// length header of HEADER_BYTES bytes, in one single-port-write RAM of
// STORE_BYTES bytes with registered read.
// Request channel: a beat is taken when start is high and busy is low.
// req_func selects write (one message byte from req_data_in; the first byte
// of a message brings req_msg_len) or read (one message byte; at a message
// start req_max_len is the reader's capacity).
// Response channel: exactly one beat per request, shown for one cycle with
// rsp_valid high; the receiver cannot stall, so each beat must be taken.
// Path of a request: a zero-length or refused write and an empty read
// answer from idle; a following write byte goes via ST_WR_BYTE, the first
// write byte via ST_WR_HDR for each header byte, then ST_WR_BYTE; a
// following read byte via ST_RD_BYTE, the first read byte via ST_RD_HDR
// (header bytes come back one RAM read at a time), ST_RD_LEN and
// ST_RD_BYTE; too-long and zero-length header reads answer from ST_RD_LEN.
// busy is low on the response cycle: the next request may follow directly.
// Reset clears all pointers and counters: the store is empty afterwards.
// Store contents are not cleared and need no clearing pass.
module length_prefixed_message_fifo
   import lpmf_pkg::*;
#(
   parameter int STORE_BYTES  = 4096,
   parameter int HEADER_BYTES = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_func,
   input  logic [BYTE_W-1:0]   req_data_in,
   input  logic [LEN_W-1:0]    req_msg_len,
   input  logic [LEN_W-1:0]    req_max_len,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [BYTE_W-1:0]   rsp_data_out,
   output logic                rsp_data_valid,
   output logic                rsp_last,
   output logic [LEN_W-1:0]    rsp_msg_len_out
);

   localparam int ADDR_W = $clog2(STORE_BYTES);
   localparam int PTR_W  = ADDR_W + 1;
   localparam int CMP_W  = (PTR_W + 1 > LEN_W + 1) ? PTR_W + 1 : LEN_W + 1;
   localparam int HC_W   = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
   localparam int HDR_READS = (HEADER_BYTES >= 2) ? 2 : 1;

   localparam logic [PTR_W:0]   SPAN     = (PTR_W + 1)'(2 * STORE_BYTES);
   localparam logic [PTR_W:0]   CAP      = (PTR_W + 1)'(STORE_BYTES);
   localparam logic [PTR_W-1:0] HDR_STEP = PTR_W'(HEADER_BYTES);
   localparam logic [PTR_W-1:0] ONE_STEP = PTR_W'(1);
   localparam logic [HC_W-1:0]  HC_LAST_WR = HC_W'(HEADER_BYTES - 1);
   localparam logic [HC_W-1:0]  HC_LAST_RD = HC_W'(HDR_READS - 1);
   localparam logic [LEN_W-1:0] LEN_LIMIT =
      (HEADER_BYTES >= 2) ? LEN_LIMIT_FULL : LEN_LIMIT_SHORT;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WR_HDR,
      ST_WR_BYTE,
      ST_RD_HDR,
      ST_RD_LEN,
      ST_RD_BYTE
   } state_type;

   // Advance a pointer that counts modulo twice the store size
   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                input logic [PTR_W-1:0] n);
      logic [PTR_W:0] q;
      q = {1'b0, p} + {1'b0, n};
      if (q >= SPAN) begin
         q = q - SPAN;
      end
      return q[PTR_W-1:0];
   endfunction

   // Map a pointer to its store address
   function automatic logic [ADDR_W-1:0] ptr_idx(input logic [PTR_W-1:0] p);
      logic [PTR_W:0] q;
      q = {1'b0, p};
      if (q >= CAP) begin
         q = q - CAP;
      end
      return q[ADDR_W-1:0];
   endfunction

   state_type            state_ff, state_in;
   logic [BYTE_W-1:0]    data_ff, data_in;
   logic [LEN_W-1:0]     mlen_ff, mlen_in;
   logic [LEN_W-1:0]     maxl_ff, maxl_in;
   logic [PTR_W-1:0]     wc_ff, wc_in;
   logic [PTR_W-1:0]     ww_ff, ww_in;
   logic [PTR_W-1:0]     rc_ff, rc_in;
   logic [PTR_W-1:0]     rw_ff, rw_in;
   logic [LEN_W-1:0]     wleft_ff, wleft_in;
   logic [LEN_W-1:0]     rleft_ff, rleft_in;
   logic [LEN_W-1:0]     rlen_ff, rlen_in;
   logic [HC_W-1:0]      hcnt_ff, hcnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [BYTE_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                 rsp_dvalid_ff, rsp_dvalid_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]     rsp_len_ff, rsp_len_in;

   logic                 accept;
   logic [PTR_W:0]       used_bytes;
   logic [PTR_W:0]       free_bytes;
   logic [CMP_W-1:0]     need_cmp;
   logic [CMP_W-1:0]     free_cmp;
   logic                 refuse;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [BYTE_W-1:0]    ram_wdata;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [BYTE_W-1:0]    ram_rdata;
   logic [PTR_W-1:0]     ptr_next;
   logic [LEN_W-1:0]     left_next;

   lpmf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Committed occupancy and the space and length check for a new message
   always_comb begin
      if (wc_ff >= rc_ff) begin
         used_bytes = {1'b0, wc_ff} - {1'b0, rc_ff};
      end else begin
         used_bytes = {1'b0, wc_ff} + SPAN - {1'b0, rc_ff};
      end
      free_bytes = CAP - used_bytes;
      need_cmp   = CMP_W'(req_msg_len) + CMP_W'(HEADER_BYTES);
      free_cmp   = CMP_W'(free_bytes);
      refuse     = (req_msg_len > LEN_LIMIT) || (need_cmp > free_cmp);
   end

   // Sequence one request: header accesses, byte access, response
   always_comb begin
      state_in      = state_ff;
      data_in       = data_ff;
      mlen_in       = mlen_ff;
      maxl_in       = maxl_ff;
      wc_in         = wc_ff;
      ww_in         = ww_ff;
      rc_in         = rc_ff;
      rw_in         = rw_ff;
      wleft_in      = wleft_ff;
      rleft_in      = rleft_ff;
      rlen_in       = rlen_ff;
      hcnt_in       = hcnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_data_in   = '0;
      rsp_dvalid_in = 1'b0;
      rsp_last_in   = 1'b0;
      rsp_len_in    = '0;
      ram_we        = 1'b0;
      ram_waddr     = ptr_idx(ww_ff);
      ram_wdata     = data_ff;
      ram_raddr     = ptr_idx(rw_ff);
      ptr_next      = ptr_add(ww_ff, ONE_STEP);
      left_next     = wleft_ff - LEN_W'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               data_in = req_data_in;
               mlen_in = req_msg_len;
               maxl_in = req_max_len;
               hcnt_in = '0;
               if (req_func == FUNC_WRITE) begin
                  if (wleft_ff != '0) begin
                     state_in = ST_WR_BYTE;
                  end else if (req_msg_len == '0) begin
                     rsp_valid_in = 1'b1;
                  end else if (refuse) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_NO_SPACE;
                  end else begin
                     state_in = ST_WR_HDR;
                  end
               end else begin
                  if (rleft_ff != '0) begin
                     // issue the byte read now, data lands next cycle
                     ram_raddr = ptr_idx(rw_ff);
                     state_in  = ST_RD_BYTE;
                  end else if (wc_ff == rc_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_EMPTY;
                  end else begin
                     ram_raddr = ptr_idx(rc_ff);
                     rlen_in   = '0;
                     state_in  = ST_RD_HDR;
                  end
               end
            end
         end

         ST_WR_HDR: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_idx(ptr_add(wc_ff, PTR_W'(hcnt_ff)));
            if (hcnt_ff == HC_W'(0)) begin
               ram_wdata = mlen_ff[BYTE_W-1:0];
            end else if (hcnt_ff == HC_W'(1)) begin
               ram_wdata = BYTE_W'(mlen_ff[LEN_W-1:BYTE_W]);
            end else begin
               ram_wdata = '0;
            end
            if (hcnt_ff == HC_LAST_WR) begin
               ww_in    = ptr_add(wc_ff, HDR_STEP);
               wleft_in = mlen_ff;
               state_in = ST_WR_BYTE;
            end else begin
               hcnt_in = hcnt_ff + HC_W'(1);
            end
         end

         ST_WR_BYTE: begin
            ram_we       = 1'b1;
            ram_waddr    = ptr_idx(ww_ff);
            ram_wdata    = data_ff;
            ww_in        = ptr_next;
            wleft_in     = left_next;
            rsp_valid_in = 1'b1;
            if (left_next == '0) begin
               // commit the whole message to the reader
               wc_in       = ptr_next;
               rsp_last_in = 1'b1;
            end
            state_in = ST_IDLE;
         end

         ST_RD_HDR: begin
            if (hcnt_ff == HC_W'(0)) begin
               rlen_in[BYTE_W-1:0] = ram_rdata;
            end else begin
               rlen_in[LEN_W-1:BYTE_W] = ram_rdata[LEN_W-BYTE_W-1:0];
            end
            if (hcnt_ff == HC_LAST_RD) begin
               state_in = ST_RD_LEN;
            end else begin
               // fetch the next header byte behind this one
               hcnt_in   = hcnt_ff + HC_W'(1);
               ram_raddr = ptr_idx(ptr_add(rc_ff, PTR_W'(hcnt_ff) + ONE_STEP));
            end
         end

         ST_RD_LEN: begin
            if (rlen_ff == '0) begin
               // skip an empty message
               rc_in        = ptr_add(rc_ff, HDR_STEP);
               rw_in        = ptr_add(rc_ff, HDR_STEP);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (rlen_ff > maxl_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_TOO_LONG;
               rsp_len_in    = rlen_ff;
               state_in      = ST_IDLE;
            end else begin
               rw_in     = ptr_add(rc_ff, HDR_STEP);
               rleft_in  = rlen_ff;
               ram_raddr = ptr_idx(ptr_add(rc_ff, HDR_STEP));
               state_in  = ST_RD_BYTE;
            end
         end

         ST_RD_BYTE: begin
            ptr_next      = ptr_add(rw_ff, ONE_STEP);
            left_next     = rleft_ff - LEN_W'(1);
            rw_in         = ptr_next;
            rleft_in      = left_next;
            rsp_valid_in  = 1'b1;
            rsp_data_in   = ram_rdata;
            rsp_dvalid_in = 1'b1;
            rsp_len_in    = rlen_ff;
            if (left_next == '0) begin
               // free the message space
               rc_in       = ptr_next;
               rsp_last_in = 1'b1;
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, pointers and the response beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wc_ff        <= '0;
         ww_ff        <= '0;
         rc_ff        <= '0;
         rw_ff        <= '0;
         wleft_ff     <= '0;
         rleft_ff     <= '0;
         hcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wc_ff        <= wc_in;
         ww_ff        <= ww_in;
         rc_ff        <= rc_in;
         rw_ff        <= rw_in;
         wleft_ff     <= wleft_in;
         rleft_ff     <= rleft_in;
         hcnt_ff      <= hcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      data_ff       <= data_in;
      mlen_ff       <= mlen_in;
      maxl_ff       <= maxl_in;
      rlen_ff       <= rlen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_dvalid_ff <= rsp_dvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_data_valid  = rsp_dvalid_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_msg_len_out = rsp_len_ff;

`include "length_prefixed_message_fifo_macros.svh"

   `LPMF_ASSERT(a_rsp_on_idle, rsp_valid |-> (state_ff == ST_IDLE), "response beat while busy")
   `LPMF_ASSERT(a_accept_progress, accept |=> (busy || rsp_valid), "accepted beat dropped")
   `LPMF_ASSERT(a_used_bound, used_bytes <= CAP, "committed occupancy beyond store size")
   `LPMF_ASSERT(a_data_beat, (rsp_valid && rsp_data_valid) |-> ((rsp_status == STATUS_OK) && (rsp_msg_len_out != '0)), "data beat with bad status or length")
   `LPMF_ASSERT_ALWAYS(a_quiet_after_reset, $past(reset) |-> !rsp_valid, "response beat right after reset")

endmodule

@@ sim/tb_length_prefixed_message_fifo.sv @@
`timescale 1ns / 1ps

module tb_length_prefixed_message_fifo;
   import lpmf_pkg::*;

   localparam int STORE_BYTES  = 4096;
   localparam int HDR          = 2;
   localparam int ADDR_W       = $clog2(STORE_BYTES);
   localparam int PTR_W        = ADDR_W + 1;
   localparam int HALF_PERIOD  = 6;
   localparam int RANDOM_ITEMS = 2000;

   // One response beat as the block should present it
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   data;
      logic                data_valid;
      logic                last;
      logic [LEN_W-1:0]    len_out;
   } reply_beat_type;

   // Shadow copy of the message ring plus the replies still owed by the block
   class message_ring_tracker;
      logic [BYTE_W-1:0] ring [STORE_BYTES];
      logic [PTR_W-1:0]  wr_commit, wr_work, rd_commit, rd_work;
      logic [LEN_W-1:0]  wr_left, rd_left;
      reply_beat_type    owed_replies[$];
      int errors, writes, reads, bytes_read;
      int status_seen[4];

      function new();
         wr_commit = '0;
         wr_work   = '0;
         rd_commit = '0;
         rd_work   = '0;
         wr_left   = '0;
         rd_left   = '0;
         errors    = 0;
         writes    = 0;
         reads     = 0;
         bytes_read = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function logic [ADDR_W-1:0] slot(input logic [PTR_W-1:0] p);
         return p[ADDR_W-1:0];
      endfunction

      function int used();
         logic [PTR_W-1:0] diff;
         diff = wr_commit - rd_commit;
         return int'(diff);
      endfunction

      function int free_bytes();
         return STORE_BYTES - used();
      endfunction

      // Length recorded in the header of the oldest committed message
      function logic [LEN_W-1:0] head_len();
         logic [31:0] v;
         v = '0;
         for (int i = 0; i < HDR; i++)
            v = v | ({24'd0, ring[slot(rd_commit + PTR_W'(i))]} << (8 * i));
         return v[LEN_W-1:0];
      endfunction

      // Work out the reply to an accepted request beat and queue it
      function void note_request(input logic func, input logic [BYTE_W-1:0] din,
                                 input logic [LEN_W-1:0] mlen,
                                 input logic [LEN_W-1:0] cap);
         reply_beat_type   rsp;
         logic [LEN_W-1:0] len;
         logic [LEN_W-1:0] limit;
         rsp = '0;
         limit = (HDR >= 2) ? LEN_LIMIT_FULL : LEN_LIMIT_SHORT;
         if (func == FUNC_WRITE) begin
            writes++;
            if (wr_left == 0) begin
               if (mlen == 0) begin
                  rsp.status = STATUS_OK;
               end else if (mlen > limit || int'(mlen) + HDR > free_bytes()) begin
                  rsp.status = STATUS_NO_SPACE;
               end else begin
                  // lay down the header, then the first byte behind it
                  for (int i = 0; i < HDR; i++)
                     ring[slot(wr_commit + PTR_W'(i))] =
                        8'((32'(mlen) >> (8 * i)) & 32'hFF);
                  wr_work = wr_commit + PTR_W'(HDR);
                  ring[slot(wr_work)] = din;
                  wr_work = wr_work + 1'b1;
                  wr_left = mlen - 1'b1;
                  if (wr_left == 0) begin
                     rsp.last = 1'b1;
                     wr_commit = wr_work;
                  end
               end
            end else begin
               ring[slot(wr_work)] = din;
               wr_work = wr_work + 1'b1;
               wr_left = wr_left - 1'b1;
               if (wr_left == 0) begin
                  rsp.last = 1'b1;
                  wr_commit = wr_work;
               end
            end
         end else begin
            reads++;
            if (rd_left == 0) begin
               if (used() == 0) begin
                  rsp.status = STATUS_EMPTY;
               end else begin
                  len = head_len();
                  if (len == 0) begin
                     // skip an empty header without delivering data
                     rd_commit = rd_commit + PTR_W'(HDR);
                     rd_work = rd_commit;
                  end else if (len > cap) begin
                     rsp.status = STATUS_TOO_LONG;
                     rsp.len_out = len;
                  end else begin
                     rd_work = rd_commit + PTR_W'(HDR);
                     rsp.data = ring[slot(rd_work)];
                     rsp.data_valid = 1'b1;
                     rsp.len_out = len;
                     rd_work = rd_work + 1'b1;
                     rd_left = len - 1'b1;
                     if (rd_left == 0) begin
                        rsp.last = 1'b1;
                        rd_commit = rd_work;
                     end
                  end
               end
            end else begin
               rsp.len_out = head_len();
               rsp.data = ring[slot(rd_work)];
               rsp.data_valid = 1'b1;
               rd_work = rd_work + 1'b1;
               rd_left = rd_left - 1'b1;
               if (rd_left == 0) begin
                  rsp.last = 1'b1;
                  rd_commit = rd_work;
               end
            end
         end
         owed_replies.push_back(rsp);
      endfunction

      // Compare a response beat against the oldest owed reply
      function void check_response(input logic [STATUS_W-1:0] status,
                                   input logic [BYTE_W-1:0] data,
                                   input logic data_valid, input logic last,
                                   input logic [LEN_W-1:0] len_out);
         reply_beat_type want;
         if (owed_replies.size() == 0) begin
            $error("response beat with no request outstanding");
            errors++;
            return;
         end
         want = owed_replies.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
         if (data !== want.data) begin
            $error("data_out: expected 0x%02h, actual 0x%02h", want.data, data);
            errors++;
         end
         if (data_valid !== want.data_valid) begin
            $error("data_valid: expected %0d, actual %0d", want.data_valid, data_valid);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            errors++;
         end
         if (len_out !== want.len_out) begin
            $error("msg_len_out: expected %0d, actual %0d", want.len_out, len_out);
            errors++;
         end
         status_seen[want.status]++;
         if (want.data_valid) bytes_read++;
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_func = FUNC_WRITE;
   logic [BYTE_W-1:0]   req_data_in = '0;
   logic [LEN_W-1:0]    req_msg_len = '0;
   logic [LEN_W-1:0]    req_max_len = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [BYTE_W-1:0]   rsp_data_out;
   logic                rsp_data_valid;
   logic                rsp_last;
   logic [LEN_W-1:0]    rsp_msg_len_out;

   message_ring_tracker tracker = new();
   int idle_pct = 25;

   length_prefixed_message_fifo #(
      .STORE_BYTES  (STORE_BYTES),
      .HEADER_BYTES (HDR)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_data_in     (req_data_in),
      .req_msg_len     (req_msg_len),
      .req_max_len     (req_max_len),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_data_valid  (rsp_data_valid),
      .rsp_last        (rsp_last),
      .rsp_msg_len_out (rsp_msg_len_out)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Check every response beat at the edge that takes it
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         tracker.check_response(rsp_status, rsp_data_out, rsp_data_valid, rsp_last,
                                rsp_msg_len_out);
   end

   // Present one request beat, hold it until taken, then maybe idle a while
   task automatic send_req(input logic func, input logic [BYTE_W-1:0] din,
                           input logic [LEN_W-1:0] mlen, input logic [LEN_W-1:0] cap);
      int gap;
      req_func    <= func;
      req_data_in <= din;
      req_msg_len <= mlen;
      req_max_len <= cap;
      start       <= 1'b1;
      do @(posedge clock); while (busy);
      tracker.note_request(func, din, mlen, cap);
      if ($urandom_range(99) < idle_pct) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int               pick, free, lo, phase, wr_pct, waited;
      logic [LEN_W-1:0] mlen, cap, len;
      logic [BYTE_W-1:0] din;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty reads, zero and oversized lengths, capacity limits
      send_req(FUNC_READ, 8'h00, 12'd0, 12'd0);
      send_req(FUNC_READ, 8'hFF, 12'hFFF, 12'hFFF);
      send_req(FUNC_WRITE, 8'h3C, 12'd0, 12'd0);
      send_req(FUNC_WRITE, 8'hC3, 12'hFFF, 12'hFFF);
      send_req(FUNC_WRITE, 8'hFF, 12'd1, 12'd0);
      send_req(FUNC_READ, 8'h00, 12'd0, 12'd0);
      send_req(FUNC_READ, 8'h00, 12'hFFF, 12'd1);
      send_req(FUNC_READ, 8'h00, 12'd0, 12'hFFF);
      // Mid-message length fields are ignored
      send_req(FUNC_WRITE, 8'h00, 12'd3, 12'hFFF);
      send_req(FUNC_WRITE, 8'hA5, 12'd0, 12'd0);
      send_req(FUNC_WRITE, 8'h5A, 12'hFFF, 12'hAAA);
      // Open a second message, read the first, and see the open one stay hidden
      send_req(FUNC_WRITE, 8'h80, 12'd2, 12'h555);
      send_req(FUNC_READ, 8'h00, 12'h0F0, 12'd3);
      send_req(FUNC_READ, 8'h00, 12'h00F, 12'd0);
      send_req(FUNC_READ, 8'h00, 12'h800, 12'h001);
      send_req(FUNC_READ, 8'h00, 12'd0, 12'hFFF);
      send_req(FUNC_WRITE, 8'h01, 12'hFFF, 12'h000);
      send_req(FUNC_READ, 8'h00, 12'd0, 12'hFFF);
      send_req(FUNC_READ, 8'h00, 12'd0, 12'd0);
      send_req(FUNC_READ, 8'h00, 12'd0, 12'd0);

      // Random: interleaved message streams, phases shift the mix and the idling
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         phase = n / 250;
         idle_pct = (phase % 3 == 1) ? 0 : 20 + 15 * (phase % 4);
         wr_pct = (phase % 4 == 1) ? 75 : (phase % 4 == 3) ? 30 : 50;
         din  = 8'($urandom);
         mlen = LEN_W'($urandom);
         cap  = LEN_W'($urandom);
         if ($urandom_range(99) < wr_pct) begin
            if (tracker.wr_left == 0) begin
               pick = $urandom_range(99);
               free = tracker.free_bytes();
               if (pick < 5) begin
                  mlen = '0;
               end else if (pick < 12) begin
                  // ask for more than fits
                  lo = (free > HDR) ? free - HDR + 1 : 1;
                  mlen = LEN_W'($urandom_range(4095, lo));
               end else if (pick < 20) begin
                  mlen = LEN_W'($urandom_range(300, 25));
               end else begin
                  mlen = LEN_W'($urandom_range(24, 1));
               end
            end
            send_req(FUNC_WRITE, din, mlen, cap);
         end else begin
            if (tracker.rd_left == 0 && tracker.used() != 0) begin
               len = tracker.head_len();
               pick = $urandom_range(99);
               if (pick < 12 && len > 0)
                  cap = LEN_W'($urandom_range(int'(len) - 1, 0));
               else if (pick >= 20)
                  cap = LEN_W'($urandom_range(4095, int'(len)));
            end
            send_req(FUNC_READ, din, mlen, cap);
         end
      end

      // Drain the remaining response beats
      start <= 1'b0;
      waited = 0;
      while (tracker.owed_replies.size() != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (16) @(posedge clock);
      if (tracker.owed_replies.size() != 0) begin
         $error("%0d response beats never arrived", tracker.owed_replies.size());
         tracker.errors++;
      end

      $display("Ran %0d writes and %0d reads; %0d message bytes came back out of the ring.",
               tracker.writes, tracker.reads, tracker.bytes_read);
      $display("Statuses seen: ok %0d, no space %0d, empty %0d, too long %0d.",
               tracker.status_seen[STATUS_OK], tracker.status_seen[STATUS_NO_SPACE],
               tracker.status_seen[STATUS_EMPTY], tracker.status_seen[STATUS_TOO_LONG]);
      if (tracker.errors == 0)
         $display("tb_length_prefixed_message_fifo passed");
      else
         $display("tb_length_prefixed_message_fifo failed");
      $finish;
   end

   // Stop a hung run
   initial begin
      #(10_000_000);
      $display("tb_length_prefixed_message_fifo failed");
      $finish;
   end

endmodule

@@ length_prefixed_message_fifo.f @@
+incdir+design
design/lpmf_pkg.sv
design/lpmf_ram.sv
design/length_prefixed_message_fifo.sv
sim/tb_length_prefixed_message_fifo.sv
